>>> hdl/thick_line_pixel_generator_top_assert.svh
// Assertion macros for the thick line pixel generator.
`ifndef THICK_LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define THICK_LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TLPG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlpg assertion failed");
`define TLPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlpg assertion failed");
`else
`define TLPG_ASSERT_SAME(lbl, ante, cons)
`define TLPG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/tlpg_pkg.sv
// Types and constants shared by the thick line pixel generator modules.
package tlpg_pkg;

  localparam int COORD_BITS = 10;
  localparam int THICK_BITS = 6;
  localparam int PIX_BITS   = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int COLOR_BITS = 8;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [THICK_BITS-1:0] thickness;
    logic [COLOR_BITS-1:0] color_in;
  } in_item_t;

  typedef struct packed {
    logic                  pixel_valid;
    logic [PIX_BITS-1:0]   pixel_x;
    logic [PIX_BITS-1:0]   pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic                  busy;
    logic [COLOR_BITS-1:0] line_color;
  } core_status_t;

endpackage

>>> hdl/tlpg_core.sv
// Line state registers and the per-transfer Bresenham step with thickness offsets.
module tlpg_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  tlpg_pkg::in_item_t   item,
  output tlpg_pkg::out_item_t  result,
  output tlpg_pkg::core_status_t status
);

  localparam int CB = tlpg_pkg::COORD_BITS;
  localparam int TB = tlpg_pkg::THICK_BITS;
  localparam int PB = tlpg_pkg::PIX_BITS;
  localparam int EB = tlpg_pkg::ERR_BITS;
  localparam int KB = tlpg_pkg::COLOR_BITS;

  logic [CB-1:0]        cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CB-1:0]        target_x_r, target_x_nxt, target_y_r, target_y_nxt;
  logic [CB-1:0]        delta_x_r, delta_x_nxt, delta_y_r, delta_y_nxt;
  logic                 step_x_neg_r, step_x_neg_nxt, step_y_neg_r, step_y_neg_nxt;
  logic signed [EB-1:0] err_r, err_nxt;
  logic [TB-1:0]        offset_r, offset_nxt;
  logic [TB-1:0]        thick_r, thick_nxt;
  logic [KB-1:0]        color_r, color_nxt;
  logic                 x_major_r, x_major_nxt;
  logic                 busy_r, busy_nxt;

  logic [CB-1:0]        dx_new, dy_new;
  logic [TB:0]          off_inc;
  logic                 point_done, at_end, move_x, move_y;
  logic signed [EB:0]   e2, dx_s, dy_s;
  logic signed [EB-1:0] err_adj;
  logic [PB-1:0]        off_ext;

  always_comb begin
    dx_new = (item.x_end >= item.x_start) ? item.x_end - item.x_start
                                          : item.x_start - item.x_end;
    dy_new = (item.y_end >= item.y_start) ? item.y_end - item.y_start
                                          : item.y_start - item.y_end;

    off_inc    = {1'b0, offset_r} + {{TB{1'b0}}, 1'b1};
    point_done = (off_inc >= {1'b0, thick_r});
    at_end     = (cur_x_r == target_x_r) && (cur_y_r == target_y_r);
    e2         = {err_r, 1'b0};
    dx_s       = $signed({3'b000, delta_x_r});
    dy_s       = $signed({3'b000, delta_y_r});
    move_x     = (e2 > -dy_s);
    move_y     = (e2 < dx_s);
    err_adj    = err_r - (move_x ? dy_s[EB-1:0] : '0) + (move_y ? dx_s[EB-1:0] : '0);
    off_ext    = {{(PB-TB){1'b0}}, offset_r};

    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    target_x_nxt   = target_x_r;
    target_y_nxt   = target_y_r;
    delta_x_nxt    = delta_x_r;
    delta_y_nxt    = delta_y_r;
    step_x_neg_nxt = step_x_neg_r;
    step_y_neg_nxt = step_y_neg_r;
    err_nxt        = err_r;
    offset_nxt     = offset_r;
    thick_nxt      = thick_r;
    color_nxt      = color_r;
    x_major_nxt    = x_major_r;
    busy_nxt       = busy_r;
    result         = '0;

    if (item.mode == tlpg_pkg::MODE_START) begin
      cur_x_nxt      = item.x_start;
      cur_y_nxt      = item.y_start;
      target_x_nxt   = item.x_end;
      target_y_nxt   = item.y_end;
      delta_x_nxt    = dx_new;
      delta_y_nxt    = dy_new;
      step_x_neg_nxt = !(item.x_start < item.x_end);
      step_y_neg_nxt = !(item.y_start < item.y_end);
      err_nxt        = $signed({2'b00, dx_new}) - $signed({2'b00, dy_new});
      offset_nxt     = '0;
      thick_nxt      = item.thickness;
      color_nxt      = item.color_in;
      x_major_nxt    = (dx_new > dy_new);
      busy_nxt       = (item.thickness != '0);
    end else if (busy_r) begin
      result.pixel_valid = 1'b1;
      result.pixel_x     = {1'b0, cur_x_r} + (x_major_r ? '0 : off_ext);
      result.pixel_y     = {1'b0, cur_y_r} + (x_major_r ? off_ext : '0);
      result.pixel_color = color_r;
      result.last        = point_done && at_end;
      offset_nxt         = off_inc[TB-1:0];
      if (point_done) begin
        offset_nxt = '0;
        if (at_end) begin
          busy_nxt = 1'b0;
        end else begin
          err_nxt = err_adj;
          if (move_x) cur_x_nxt = step_x_neg_r ? cur_x_r - CB'(1) : cur_x_r + CB'(1);
          if (move_y) cur_y_nxt = step_y_neg_r ? cur_y_r - CB'(1) : cur_y_r + CB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      target_x_r   <= '0;
      target_y_r   <= '0;
      delta_x_r    <= '0;
      delta_y_r    <= '0;
      step_x_neg_r <= 1'b0;
      step_y_neg_r <= 1'b0;
      err_r        <= '0;
      offset_r     <= '0;
      thick_r      <= '0;
      color_r      <= '0;
      x_major_r    <= 1'b0;
      busy_r       <= 1'b0;
    end else if (step_en) begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      target_x_r   <= target_x_nxt;
      target_y_r   <= target_y_nxt;
      delta_x_r    <= delta_x_nxt;
      delta_y_r    <= delta_y_nxt;
      step_x_neg_r <= step_x_neg_nxt;
      step_y_neg_r <= step_y_neg_nxt;
      err_r        <= err_nxt;
      offset_r     <= offset_nxt;
      thick_r      <= thick_nxt;
      color_r      <= color_nxt;
      x_major_r    <= x_major_nxt;
      busy_r       <= busy_nxt;
    end
  end

  assign status.busy       = busy_r;
  assign status.line_color = color_r;

endmodule

>>> hdl/thick_line_pixel_generator_top.sv
// Top level of the thick line pixel generator: handshake and result register.
// Each input transfer yields exactly one result in the next cycle: an invalid one for a
// start item or for an advance item after the line ends, else one pixel. One transfer per
// cycle is sustained unless out_stall holds the result: the line state (point, error
// term, offset count) steps per transfer; the result register refills in the cycle it drains.
module thick_line_pixel_generator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlpg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tlpg_pkg::out_item_t out_data
);

  `include "thick_line_pixel_generator_top_assert.svh"

  logic                   out_valid_r;
  tlpg_pkg::out_item_t    out_data_r;
  tlpg_pkg::out_item_t    step_result;
  tlpg_pkg::core_status_t core_status;
  logic                   in_xfer;
  logic                   start_xfer;
  logic                   pixel_out;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  tlpg_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(in_xfer),
    .item   (in_data),
    .result (step_result),
    .status (core_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign start_xfer = in_xfer && (in_data.mode == tlpg_pkg::MODE_START);
  assign pixel_out  = out_valid_r && out_data_r.pixel_valid;

  // a start transfer always produces an empty result
  `TLPG_ASSERT_NEXT(a_start_invalid, start_xfer, out_valid_r && !out_data_r.pixel_valid)
  // the last pixel leaves the line finished
  `TLPG_ASSERT_SAME(a_last_idle, pixel_out && out_data_r.last, !core_status.busy)
  // pixels carry the stored line color
  `TLPG_ASSERT_SAME(a_color_match, pixel_out, out_data_r.pixel_color == core_status.line_color)

endmodule
